/* src/sfs_pkg.sv */
// ----------------------------------------------------------------------------
// sfs_pkg
// Types and constants shared by the sprite frame sequencer files.
// ----------------------------------------------------------------------------
package sfs_pkg;

   localparam int ActionW    = 4;
   localparam int TimeW      = 32;
   localparam int RateW      = 16;
   localparam int FrameW     = 8;
   localparam int CountW     = 9;
   localparam int EventW     = 7;
   localparam int CsrIndexW  = 8;
   localparam int CsrDataW   = 16;
   localparam int MaxFrames  = 256;
   localparam int ProdW      = TimeW + RateW;
   localparam int RateFrac   = 8;

   localparam logic [CsrIndexW-1:0] CSR_NUM_FRAMES = 8'd0;
   localparam logic [CsrIndexW-1:0] CSR_PLAY_RATE  = 8'd1;

   typedef enum logic [ActionW-1:0] {
      ACT_TICK      = 4'd0,
      ACT_PLAY      = 4'd1,
      ACT_RESET     = 4'd2,
      ACT_REVERSE   = 4'd3,
      ACT_FORWARD   = 4'd4,
      ACT_LOOP      = 4'd5,
      ACT_NO_LOOP   = 4'd6,
      ACT_BOUNCE    = 4'd7,
      ACT_NO_BOUNCE = 4'd8,
      ACT_SET_FRAME = 4'd9,
      ACT_SET_PAUSE = 4'd10
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ADV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic adv_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic                is_tick;
      logic                adv_go;
      logic [EventW-1:0]   events;
   } status_type;

endpackage

/* src/sfs_req_if.sv */
// ----------------------------------------------------------------------------
// sfs_req_if
// Request channel: one action item per transfer.
// ----------------------------------------------------------------------------
interface sfs_req_if;
   import sfs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ActionW-1:0]   action;
   logic [TimeW-1:0]     time_step;
   logic [TimeW-1:0]     frame_duration;
   logic [FrameW-1:0]    frame_index;
   logic                 pause_value;

   modport source (
      output valid, action, time_step, frame_duration, frame_index, pause_value,
      input  ready
   );
   modport sink (
      input  valid, action, time_step, frame_duration, frame_index, pause_value,
      output ready
   );
endinterface

/* src/sfs_rsp_if.sv */
// ----------------------------------------------------------------------------
// sfs_rsp_if
// Response channel: one result item per transfer.
// ----------------------------------------------------------------------------
interface sfs_rsp_if;
   import sfs_pkg::*;

   logic                valid;
   logic                ready;
   logic [FrameW-1:0]   current_frame;
   logic                frame_changed;
   logic [EventW-1:0]   finish_events;
   logic                is_finished;
   logic                is_bouncing;
   logic                is_paused;

   modport source (
      output valid, current_frame, frame_changed, finish_events,
             is_finished, is_bouncing, is_paused,
      input  ready
   );
   modport sink (
      input  valid, current_frame, frame_changed, finish_events,
             is_finished, is_bouncing, is_paused,
      output ready
   );
endinterface

/* src/sfs_csr_if.sv */
// ----------------------------------------------------------------------------
// sfs_csr_if
// Register write channel: index and data per transfer.
// ----------------------------------------------------------------------------
interface sfs_csr_if;
   import sfs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CsrIndexW-1:0]  index;
   logic [CsrDataW-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* src/sfs_ctrl.sv */
// ----------------------------------------------------------------------------
// sfs_ctrl
// Sequencer controller: accept, execute, iterate advances, deliver result.
// ----------------------------------------------------------------------------
module sfs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  sfs_pkg::status_type status,
   output sfs_pkg::cmd_type    cmd
);
   import sfs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.is_tick ? ST_ADV : ST_DONE;
         end
         ST_ADV: begin
            cmd.adv_step = 1'b1;
            if (!status.adv_go) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/sfs_dp.sv */
// ----------------------------------------------------------------------------
// sfs_dp
// Sequencer datapath: registers, time accumulator, advance step, result.
// ----------------------------------------------------------------------------
module sfs_dp #(
   parameter int MAX_ADVANCES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sfs_pkg::cmd_type                cmd,
   output sfs_pkg::status_type             status,
   input  logic [sfs_pkg::ActionW-1:0]     action,
   input  logic [sfs_pkg::TimeW-1:0]       time_step,
   input  logic [sfs_pkg::TimeW-1:0]       frame_duration,
   input  logic [sfs_pkg::FrameW-1:0]      frame_index,
   input  logic                            pause_value,
   input  logic                            csr_write,
   input  logic [sfs_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [sfs_pkg::CsrDataW-1:0]    csr_data,
   output logic [sfs_pkg::FrameW-1:0]      current_frame,
   output logic                            frame_changed,
   output logic [sfs_pkg::EventW-1:0]      finish_events,
   output logic                            is_finished,
   output logic                            is_bouncing,
   output logic                            is_paused
);
   import sfs_pkg::*;

   localparam int CntW = $clog2(MAX_ADVANCES + 1);
   localparam logic [CntW-1:0] CntMax = CntW'(MAX_ADVANCES);
   localparam logic [CountW-1:0] NCap = CountW'(MaxFrames);

   logic [CountW-1:0]   num_frames_ff;
   logic [RateW-1:0]    play_rate_ff;
   logic [TimeW-1:0]    elapsed_ff;
   logic [FrameW-1:0]   frame_ff;
   logic                finished_ff;
   logic                bouncing_ff;
   logic                reverse_ff;
   logic                loop_ff;
   logic                bounce_ff;
   logic                paused_ff;
   logic [ActionW-1:0]  act_ff;
   logic [TimeW-1:0]    dur_ff;
   logic [FrameW-1:0]   fidx_ff;
   logic                pv_ff;
   logic [ProdW-1:0]    prod_ff;
   logic                changed_ff;
   logic [EventW-1:0]   events_ff;
   logic [CntW-1:0]     count_ff;
   logic [FrameW-1:0]   out_frame_ff;
   logic                out_changed_ff;
   logic [EventW-1:0]   out_events_ff;
   logic                out_fin_ff;
   logic                out_bnc_ff;
   logic                out_pause_ff;

   logic [CountW-1:0]      n;
   logic [TimeW+8:0]       sum;
   logic [TimeW-1:0]       sum_sat;
   logic                   adv_go;
   logic signed [CountW:0] n_s;
   logic signed [CountW:0] nx;
   logic                   adv_fin;
   logic                   adv_bnc;
   logic                   adv_ev;
   logic [FrameW-1:0]      adv_frame;
   logic [CountW-1:0]      reset_target;

   assign n       = (num_frames_ff > NCap) ? NCap : num_frames_ff;
   assign n_s     = signed'({1'b0, n});
   assign sum     = {9'd0, elapsed_ff} + {1'b0, prod_ff[ProdW-1:RateFrac]};
   assign sum_sat = (sum[TimeW+8:TimeW] != 9'd0) ? '1 : sum[TimeW-1:0];
   assign adv_go  = (dur_ff != '0) && (elapsed_ff >= dur_ff) && (count_ff < CntMax);
   assign reset_target = (reverse_ff && n != '0) ? n - CountW'(1) : '0;

   always_comb begin
      nx      = signed'({2'b00, frame_ff});
      adv_fin = finished_ff;
      adv_bnc = bouncing_ff;
      adv_ev  = 1'b0;
      if (!reverse_ff) begin
         nx = bouncing_ff ? nx - 10'sd1 : nx + 10'sd1;
         if (nx < 10'sd0) begin
            adv_ev = !finished_ff;
            if (loop_ff) begin
               adv_bnc = 1'b0;
               nx      = 10'sd1;
            end else begin
               adv_fin = 1'b1;
               nx      = 10'sd0;
            end
         end else if (nx >= n_s) begin
            if (bounce_ff) begin
               adv_bnc = 1'b1;
               nx      = n_s - 10'sd2;
            end else begin
               adv_ev = !finished_ff;
               if (loop_ff) begin
                  nx = 10'sd0;
               end else begin
                  adv_fin = 1'b1;
                  nx      = n_s - 10'sd1;
               end
            end
         end
      end else begin
         nx = bouncing_ff ? nx + 10'sd1 : nx - 10'sd1;
         if (nx < 10'sd0) begin
            if (bounce_ff) begin
               adv_bnc = 1'b1;
               nx      = 10'sd1;
            end else begin
               adv_ev = !finished_ff;
               if (loop_ff) begin
                  nx = n_s - 10'sd1;
               end else begin
                  adv_fin = 1'b1;
                  nx      = 10'sd0;
               end
            end
         end else if (nx >= n_s) begin
            adv_ev = !finished_ff;
            if (loop_ff) begin
               adv_bnc = 1'b0;
               nx      = n_s - 10'sd2;
            end else begin
               adv_fin = 1'b1;
               nx      = n_s - 10'sd1;
            end
         end
      end
      if (nx >= n_s) begin
         nx = n_s - 10'sd1;
      end
      if (nx < 10'sd0) begin
         nx = 10'sd0;
      end
      adv_frame = nx[FrameW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_frames_ff <= CountW'(1);
         play_rate_ff  <= RateW'(256);
         elapsed_ff    <= '0;
         frame_ff      <= '0;
         finished_ff   <= 1'b0;
         bouncing_ff   <= 1'b0;
         reverse_ff    <= 1'b0;
         loop_ff       <= 1'b0;
         bounce_ff     <= 1'b0;
         paused_ff     <= 1'b0;
         changed_ff    <= 1'b0;
         events_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_NUM_FRAMES) begin
               num_frames_ff <= csr_data[CountW-1:0];
            end else if (csr_index == CSR_PLAY_RATE) begin
               play_rate_ff <= csr_data[RateW-1:0];
            end
         end
         if (cmd.accept) begin
            changed_ff <= 1'b0;
            events_ff  <= '0;
            count_ff   <= '0;
         end
         if (cmd.exec) begin
            case (action_type'(act_ff))
               ACT_TICK: begin
                  if (!paused_ff) begin
                     elapsed_ff <= sum_sat;
                  end
               end
               ACT_PLAY: begin
                  paused_ff   <= 1'b0;
                  finished_ff <= 1'b0;
               end
               ACT_RESET: begin
                  bouncing_ff <= 1'b0;
                  finished_ff <= 1'b0;
                  if (n != '0 && reset_target[FrameW-1:0] != frame_ff) begin
                     frame_ff   <= reset_target[FrameW-1:0];
                     changed_ff <= 1'b1;
                  end
               end
               ACT_REVERSE:   reverse_ff <= 1'b1;
               ACT_FORWARD:   reverse_ff <= 1'b0;
               ACT_LOOP: begin
                  loop_ff     <= 1'b1;
                  finished_ff <= 1'b0;
               end
               ACT_NO_LOOP:   loop_ff   <= 1'b0;
               ACT_BOUNCE:    bounce_ff <= 1'b1;
               ACT_NO_BOUNCE: bounce_ff <= 1'b0;
               ACT_SET_FRAME: begin
                  if ({1'b0, fidx_ff} < n && fidx_ff != frame_ff) begin
                     frame_ff   <= fidx_ff;
                     changed_ff <= 1'b1;
                  end
               end
               ACT_SET_PAUSE: begin
                  if (paused_ff != pv_ff) begin
                     paused_ff  <= pv_ff;
                     elapsed_ff <= '0;
                     if (!pv_ff) begin
                        finished_ff <= 1'b0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         if (cmd.adv_step && adv_go) begin
            frame_ff    <= adv_frame;
            finished_ff <= adv_fin;
            bouncing_ff <= adv_bnc;
            elapsed_ff  <= elapsed_ff - dur_ff;
            count_ff    <= count_ff + CntW'(1);
            events_ff   <= events_ff + EventW'(adv_ev);
            if (adv_frame != frame_ff) begin
               changed_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff  <= action;
         dur_ff  <= frame_duration;
         fidx_ff <= frame_index;
         pv_ff   <= pause_value;
         prod_ff <= ProdW'(time_step) * ProdW'(play_rate_ff);
      end
      if (cmd.load_rsp) begin
         out_frame_ff   <= frame_ff;
         out_changed_ff <= changed_ff;
         out_events_ff  <= events_ff;
         out_fin_ff     <= finished_ff;
         out_bnc_ff     <= bouncing_ff;
         out_pause_ff   <= paused_ff;
      end
   end

   assign status.is_tick = (act_ff == ACT_TICK);
   assign status.adv_go  = adv_go;
   assign status.events  = events_ff;

   assign current_frame = out_frame_ff;
   assign frame_changed = out_changed_ff;
   assign finish_events = out_events_ff;
   assign is_finished   = out_fin_ff;
   assign is_bouncing   = out_bnc_ff;
   assign is_paused     = out_pause_ff;

endmodule

/* src/sprite_frame_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_unit
// Sprite animation frame sequencer for one animation state.
// ----------------------------------------------------------------------------
// One request is processed at a time. A control action passes through the
// idle, execute and done states to its result; a tick also passes the
// advance state for its k frame advances (0 to MAX_ADVANCES), since a single
// advance unit takes one step per cycle. The next request is taken while the
// previous result still waits in the output register. Register writes are
// taken every cycle and hold no clearing pass after reset.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_unit #(
   parameter int MAX_ADVANCES = 64
) (
   input  logic      clock,
   input  logic      reset,
   sfs_req_if.sink   req_chan,
   sfs_rsp_if.source rsp_chan,
   sfs_csr_if.sink   csr_chan
);
   import sfs_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;

   sfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sfs_dp #(
      .MAX_ADVANCES (MAX_ADVANCES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .action         (req_chan.action),
      .time_step      (req_chan.time_step),
      .frame_duration (req_chan.frame_duration),
      .frame_index    (req_chan.frame_index),
      .pause_value    (req_chan.pause_value),
      .csr_write      (csr_chan.valid),
      .csr_index      (csr_chan.index),
      .csr_data       (csr_chan.data),
      .current_frame  (rsp_chan.current_frame),
      .frame_changed  (rsp_chan.frame_changed),
      .finish_events  (rsp_chan.finish_events),
      .is_finished    (rsp_chan.is_finished),
      .is_bouncing    (rsp_chan.is_bouncing),
      .is_paused      (rsp_chan.is_paused)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign csr_chan.ready = 1'b1;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> cmd.exec)
      else $error("request transfer not followed by execute");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result loaded over a pending result");

   a_events_cap: assert property (@(posedge clock) disable iff (reset)
      status.events <= EventW'(MAX_ADVANCES))
      else $error("finish events exceed advance limit");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.exec || cmd.adv_step |-> !req_chan.ready)
      else $error("request taken while an item is in progress");

endmodule
